[src/cfe_pkg.sv]
// ============================================================================
// cfe_pkg: shared types and constants of the flash command emulator
// Command codes, mode encodings, register indexes and store control word.
// ============================================================================
`default_nettype none

package cfe_pkg;

    localparam int CFE_STORE_BYTES       = 131072;
    localparam int CFE_ERASE_BLOCK_BYTES = 65536;

    localparam int SIZE_W = 18;

    localparam logic [31:0] READY_DUAL = 32'h0080_0080;

    localparam logic [7:0] CODE_READ_ARRAY     = 8'hFF;
    localparam logic [7:0] CODE_READ_ARRAY_ALT = 8'hF0;
    localparam logic [7:0] CODE_READ_STATUS    = 8'h70;
    localparam logic [7:0] CODE_READ_ID        = 8'h90;
    localparam logic [7:0] CODE_CLEAR_STATUS   = 8'h50;
    localparam logic [7:0] CODE_BYTE_PROGRAM   = 8'h10;
    localparam logic [7:0] CODE_BYTE_PROG_ALT  = 8'h40;
    localparam logic [7:0] CODE_BLOCK_ERASE    = 8'h20;
    localparam logic [7:0] CODE_BUFFER_PROGRAM = 8'hE8;
    localparam logic [7:0] CODE_CONFIRM        = 8'hD0;

    localparam logic [1:0] REG_REGION_BASE  = 2'd0;
    localparam logic [1:0] REG_REGION_BYTES = 2'd1;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_RESET = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        RM_ARRAY  = 2'd0,
        RM_STATUS = 2'd1,
        RM_ID     = 2'd2
    } read_mode_t;

    typedef enum logic [2:0] {
        WM_IDLE    = 3'd0,
        WM_BYTE    = 3'd1,
        WM_LEN     = 3'd2,
        WM_ERASE   = 3'd3,
        WM_CONFIRM = 3'd4
    } write_mode_t;

    typedef struct packed {
        logic re;
        logic we;
    } store_ctl_t;

endpackage

`default_nettype wire

[src/cfe_store.sv]
// ============================================================================
// cfe_store: byte-wide flash array
// Single-port synchronous memory, one byte per cycle, registered read data.
// ============================================================================
`default_nettype none

module cfe_store
    import cfe_pkg::*;
#(
    parameter int DEPTH = CFE_STORE_BYTES
)
(
    input  wire logic                     clk,
    input  wire store_ctl_t               ctl,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [7:0]               wdata,
    output logic      [7:0]               rdata
);

    logic [7:0] mem_reg [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem_reg[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[src/cfe_seq.sv]
// ============================================================================
// cfe_seq: command sequencer
// Bounds check, command state machine and byte walks over the flash array.
// ============================================================================
`default_nettype none

module cfe_seq
    import cfe_pkg::*;
#(
    parameter int STORE_BYTES       = CFE_STORE_BYTES,
    parameter int ERASE_BLOCK_BYTES = CFE_ERASE_BLOCK_BYTES
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [1:0]                     command,
    input  wire logic [63:0]                    address,
    input  wire logic [3:0]                     access_bytes,
    input  wire logic [63:0]                    write_data,
    input  wire logic [63:0]                    region_base,
    input  wire logic [SIZE_W-1:0]              region_bytes,
    output logic                                done,
    output logic      [63:0]                    read_data,
    output logic                                range_error,
    output logic                                protocol_warning,
    output store_ctl_t                          store_ctl,
    output logic      [$clog2(STORE_BYTES)-1:0] store_addr,
    output logic      [7:0]                     store_wdata,
    input  wire logic [7:0]                     store_rdata
);

    localparam int AW = $clog2(STORE_BYTES);
    localparam logic [31:0]       STORE_W = 32'(STORE_BYTES);
    localparam logic [SIZE_W-1:0] EBB_W   = SIZE_W'(ERASE_BLOCK_BYTES);
    localparam logic [AW-1:0]     LAST_IX = AW'(STORE_BYTES - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_READ,
        S_WRITE,
        S_ERASE
    } state_t;

    typedef struct packed {
        logic [31:0] status;
        read_mode_t  rm;
        write_mode_t wm;
        logic        unknown;
    } dec_t;

    function automatic dec_t decode(input logic [7:0] code, input logic [31:0] st,
                                    input read_mode_t rm, input write_mode_t wm);
        dec_t d;
        d.status  = st;
        d.rm      = rm;
        d.wm      = wm;
        d.unknown = 1'b0;
        case (code)
            CODE_READ_STATUS:  d.rm = RM_STATUS;
            CODE_READ_ID:      d.rm = RM_ID;
            CODE_CLEAR_STATUS: d.status = 32'd0;
            CODE_BYTE_PROGRAM, CODE_BYTE_PROG_ALT:
            begin
                d.wm = WM_BYTE;
                d.rm = RM_STATUS;
            end
            CODE_BLOCK_ERASE:
            begin
                d.status = READY_DUAL;
                d.wm     = WM_ERASE;
                d.rm     = RM_STATUS;
            end
            CODE_CONFIRM: d.unknown = 1'b0;
            CODE_BUFFER_PROGRAM:
            begin
                d.status = READY_DUAL;
                d.wm     = WM_LEN;
                d.rm     = RM_STATUS;
            end
            CODE_READ_ARRAY, CODE_READ_ARRAY_ALT: d.rm = RM_ARRAY;
            default: d.unknown = 1'b1;
        endcase
        return d;
    endfunction

    state_t      state_reg,        state_next;
    logic        is_read_reg,      is_read_next;
    logic [3:0]  n_reg,            n_next;
    logic [63:0] data_reg,         data_next;
    logic [63:0] off_reg,          off_next;
    logic        borrow_reg,       borrow_next;
    logic [AW-1:0] cnt_reg,        cnt_next;
    logic [AW-1:0] last_reg,       last_next;
    logic [63:0] acc_reg,          acc_next;
    logic        iss_done_reg,     iss_done_next;
    logic        rd_pend_reg,      rd_pend_next;
    logic [2:0]  rd_idx_reg,       rd_idx_next;
    logic        warn_reg,         warn_next;
    logic [31:0] status_reg,       status_next;
    read_mode_t  read_mode_reg,    read_mode_next;
    write_mode_t write_mode_reg,   write_mode_next;
    logic [16:0] pending_reg,      pending_next;
    logic        done_reg,         done_next;
    logic [63:0] read_data_reg,    read_data_next;
    logic        range_error_reg,  range_error_next;
    logic        protocol_warning_reg, protocol_warning_next;

    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] off_lo;
    logic [SIZE_W:0]   end_sum;
    logic [SIZE_W-1:0] rem;
    logic [SIZE_W-1:0] erase_len;
    logic              range_bad;
    logic [7:0]        code;
    logic [31:0]       status_masked;
    logic [63:0]       acc_cap;
    logic [64:0]       diff;
    dec_t              dec;

    assign size = ({{(32-SIZE_W){1'b0}}, region_bytes} < STORE_W) ?
                  region_bytes : STORE_W[SIZE_W-1:0];
    assign off_lo    = off_reg[SIZE_W-1:0];
    assign end_sum   = {1'b0, off_lo} + (SIZE_W+1)'(n_reg);
    assign range_bad = (n_reg == 4'd0) || (n_reg > 4'd8) || borrow_reg ||
                       (|off_reg[63:SIZE_W]) || (end_sum > {1'b0, size});
    assign rem       = size - off_lo;
    assign erase_len = (rem > EBB_W) ? EBB_W : rem;
    assign code      = data_reg[7:0];
    assign diff      = {1'b0, address} - {1'b0, region_base};
    assign dec       = decode(code, status_reg, read_mode_reg, write_mode_reg);

    always_comb
    begin
        status_masked = 32'd0;
        for (int k = 0; k < 4; k++)
        begin
            if (4'(k) < n_reg)
            begin
                status_masked[k*8 +: 8] = status_reg[k*8 +: 8];
            end
        end
        acc_cap = acc_reg;
        acc_cap[{rd_idx_reg, 3'b000} +: 8] = store_rdata;
    end

    always_comb
    begin
        state_next            = state_reg;
        is_read_next          = is_read_reg;
        n_next                = n_reg;
        data_next             = data_reg;
        off_next              = off_reg;
        borrow_next           = borrow_reg;
        cnt_next              = cnt_reg;
        last_next             = last_reg;
        acc_next              = acc_reg;
        iss_done_next         = iss_done_reg;
        rd_pend_next          = 1'b0;
        rd_idx_next           = rd_idx_reg;
        warn_next             = warn_reg;
        status_next           = status_reg;
        read_mode_next        = read_mode_reg;
        write_mode_next       = write_mode_reg;
        pending_next          = pending_reg;
        done_next             = 1'b0;
        read_data_next        = read_data_reg;
        range_error_next      = range_error_reg;
        protocol_warning_next = protocol_warning_reg;
        store_ctl             = '0;
        store_addr            = off_reg[AW-1:0] + cnt_reg;
        store_wdata           = 8'hFF;

        case (state_reg)
            S_CLEAR:
            begin
                store_ctl.we = 1'b1;
                store_addr   = cnt_reg;
                if (cnt_reg == LAST_IX)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    n_next       = access_bytes;
                    data_next    = write_data;
                    is_read_next = (command == CMD_READ);
                    off_next     = diff[63:0];
                    borrow_next  = diff[64];
                    if (command == CMD_RESET)
                    begin
                        status_next     = READY_DUAL;
                        read_mode_next  = RM_ARRAY;
                        write_mode_next = WM_IDLE;
                        pending_next    = 17'd0;
                    end
                    if (command == CMD_READ || command == CMD_WRITE)
                    begin
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        done_next             = 1'b1;
                        read_data_next        = 64'd0;
                        range_error_next      = 1'b0;
                        protocol_warning_next = 1'b0;
                    end
                end
            end

            S_CHECK:
            begin
                cnt_next              = '0;
                last_next             = AW'(n_reg - 4'd1);
                acc_next              = 64'd0;
                iss_done_next         = 1'b0;
                warn_next             = 1'b0;
                read_data_next        = 64'd0;
                range_error_next      = 1'b0;
                protocol_warning_next = 1'b0;
                state_next            = S_IDLE;
                if (range_bad)
                begin
                    done_next        = 1'b1;
                    range_error_next = 1'b1;
                end
                else if (is_read_reg)
                begin
                    case (read_mode_reg)
                        RM_ARRAY:  state_next = S_READ;
                        RM_STATUS:
                        begin
                            done_next      = 1'b1;
                            read_data_next = {32'd0, status_masked};
                        end
                        default:   done_next = 1'b1;
                    endcase
                end
                else
                begin
                    case (write_mode_reg)
                        WM_BYTE:
                        begin
                            status_next     = READY_DUAL;
                            write_mode_next = WM_IDLE;
                            read_mode_next  = RM_STATUS;
                            state_next      = S_WRITE;
                        end
                        WM_LEN:
                        begin
                            pending_next    = 17'(data_reg[15:0]) + 17'd1;
                            write_mode_next = WM_CONFIRM;
                            read_mode_next  = RM_STATUS;
                            done_next       = 1'b1;
                        end
                        WM_ERASE:
                        begin
                            warn_next       = (code != CODE_CONFIRM);
                            last_next       = AW'(erase_len - 1'b1);
                            status_next     = READY_DUAL;
                            write_mode_next = WM_IDLE;
                            read_mode_next  = RM_STATUS;
                            state_next      = S_ERASE;
                        end
                        WM_CONFIRM:
                        begin
                            if (pending_reg == 17'd0)
                            begin
                                done_next = 1'b1;
                                if (code != CODE_CONFIRM)
                                begin
                                    protocol_warning_next = 1'b1;
                                    status_next           = dec.status;
                                    read_mode_next        = dec.rm;
                                    write_mode_next       = dec.wm;
                                end
                                else
                                begin
                                    write_mode_next = WM_IDLE;
                                    read_mode_next  = RM_STATUS;
                                end
                            end
                            else
                            begin
                                warn_next    = (n_reg != 4'd4);
                                pending_next = pending_reg - 17'd1;
                                state_next   = S_WRITE;
                            end
                        end
                        default:
                        begin
                            done_next             = 1'b1;
                            protocol_warning_next = dec.unknown;
                            status_next           = dec.status;
                            read_mode_next        = dec.rm;
                            write_mode_next       = dec.wm;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                if (!iss_done_reg)
                begin
                    store_ctl.re = 1'b1;
                    if (cnt_reg == last_reg)
                    begin
                        iss_done_next = 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                rd_pend_next = !iss_done_reg;
                rd_idx_next  = cnt_reg[2:0];
                if (rd_pend_reg)
                begin
                    acc_next = acc_cap;
                    if (rd_idx_reg == last_reg[2:0])
                    begin
                        done_next      = 1'b1;
                        read_data_next = acc_cap;
                        state_next     = S_IDLE;
                    end
                end
            end

            S_WRITE, S_ERASE:
            begin
                store_ctl.we = 1'b1;
                if (state_reg == S_WRITE)
                begin
                    store_wdata = data_reg[{cnt_reg[2:0], 3'b000} +: 8];
                end
                if (cnt_reg == last_reg)
                begin
                    done_next             = 1'b1;
                    protocol_warning_next = warn_reg;
                    state_next            = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_CLEAR;
            is_read_reg          <= 1'b0;
            n_reg                <= 4'd0;
            data_reg             <= 64'd0;
            off_reg              <= 64'd0;
            borrow_reg           <= 1'b0;
            cnt_reg              <= '0;
            last_reg             <= '0;
            acc_reg              <= 64'd0;
            iss_done_reg         <= 1'b0;
            rd_pend_reg          <= 1'b0;
            rd_idx_reg           <= 3'd0;
            warn_reg             <= 1'b0;
            status_reg           <= READY_DUAL;
            read_mode_reg        <= RM_ARRAY;
            write_mode_reg       <= WM_IDLE;
            pending_reg          <= 17'd0;
            done_reg             <= 1'b0;
            read_data_reg        <= 64'd0;
            range_error_reg      <= 1'b0;
            protocol_warning_reg <= 1'b0;
        end
        else
        begin
            state_reg            <= state_next;
            is_read_reg          <= is_read_next;
            n_reg                <= n_next;
            data_reg             <= data_next;
            off_reg              <= off_next;
            borrow_reg           <= borrow_next;
            cnt_reg              <= cnt_next;
            last_reg             <= last_next;
            acc_reg              <= acc_next;
            iss_done_reg         <= iss_done_next;
            rd_pend_reg          <= rd_pend_next;
            rd_idx_reg           <= rd_idx_next;
            warn_reg             <= warn_next;
            status_reg           <= status_next;
            read_mode_reg        <= read_mode_next;
            write_mode_reg       <= write_mode_next;
            pending_reg          <= pending_next;
            done_reg             <= done_next;
            read_data_reg        <= read_data_next;
            range_error_reg      <= range_error_next;
            protocol_warning_reg <= protocol_warning_next;
        end
    end

    assign busy             = (state_reg != S_IDLE);
    assign done             = done_reg;
    assign read_data        = read_data_reg;
    assign range_error      = range_error_reg;
    assign protocol_warning = protocol_warning_reg;

`ifndef NO_ASSERTIONS
    a_no_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !store_ctl.we)
        else $error("store written while sequencer idle");

    a_range_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && range_error_reg |-> !protocol_warning_reg && read_data_reg == 64'd0)
        else $error("range error word carries data or warning");

    a_upper_bytes_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && n_reg != 4'd0 && n_reg < 4'd8 |->
        (read_data_reg >> {n_reg, 3'b000}) == 64'd0)
        else $error("read word has bytes beyond access size");

    a_read_pending_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> state_reg == S_READ)
        else $error("read data pending outside read walk");
`endif

endmodule

`default_nettype wire

[src/cfi_flash_command_emulator_core.sv]
// ============================================================================
// cfi_flash_command_emulator_core: flash variable store with CFI commands
// Bus reads, writes and device resets against a byte-wide flash array.
// ============================================================================
// Usage:
//   Command channel: an item is taken at a clock edge with start high and
//   busy low. Each item gives exactly one result word, shown on read_data,
//   range_error and protocol_warning for one cycle while done is high; the
//   receiver cannot stall and must take it then. busy is already low in the
//   done cycle, so the next item may be taken at the end of that cycle.
//   Device resets and unused codes are answered straight from idle; a read
//   or write first passes a bounds check, and array reads, data writes and
//   block erases then walk their bytes through the array port, which
//   moves one byte per cycle.
//   Configuration: cfg_valid/cfg_ready write channel, index 0 region_base,
//   index 1 region_bytes; other indexes are dropped. Write only when idle.
//   Reset: a clearing pass fills all STORE_BYTES bytes of the array with 0xFF,
//   busy stays high until it ends; configuration writes are taken meanwhile.
// ============================================================================
`default_nettype none

module cfi_flash_command_emulator_core
    import cfe_pkg::*;
#(
    parameter int STORE_BYTES       = CFE_STORE_BYTES,
    parameter int ERASE_BLOCK_BYTES = CFE_ERASE_BLOCK_BYTES
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  command,
    input  wire logic [63:0] address,
    input  wire logic [3:0]  access_bytes,
    input  wire logic [63:0] write_data,
    output logic             done,
    output logic      [63:0] read_data,
    output logic             range_error,
    output logic             protocol_warning,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    localparam int AW = $clog2(STORE_BYTES);

    logic [63:0]       region_base_reg;
    logic [SIZE_W-1:0] region_bytes_reg;

    store_ctl_t        store_ctl;
    logic [AW-1:0]     store_addr;
    logic [7:0]        store_wdata;
    logic [7:0]        store_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_base_reg  <= 64'd0;
            region_bytes_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_REGION_BASE:  region_base_reg  <= cfg_data;
                REG_REGION_BYTES: region_bytes_reg <= cfg_data[SIZE_W-1:0];
                default:          region_base_reg  <= region_base_reg;
            endcase
        end
    end

    cfe_seq #(
        .STORE_BYTES       (STORE_BYTES),
        .ERASE_BLOCK_BYTES (ERASE_BLOCK_BYTES)
    ) u_seq (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .command          (command),
        .address          (address),
        .access_bytes     (access_bytes),
        .write_data       (write_data),
        .region_base      (region_base_reg),
        .region_bytes     (region_bytes_reg),
        .done             (done),
        .read_data        (read_data),
        .range_error      (range_error),
        .protocol_warning (protocol_warning),
        .store_ctl        (store_ctl),
        .store_addr       (store_addr),
        .store_wdata      (store_wdata),
        .store_rdata      (store_rdata)
    );

    cfe_store #(
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .ctl   (store_ctl),
        .addr  (store_addr),
        .wdata (store_wdata),
        .rdata (store_rdata)
    );

endmodule

`default_nettype wire

[tb/tb_cfi_flash_command_emulator_core.sv]
// ============================================================================
// tb_cfi_flash_command_emulator_core: self-checking bench for the flash core
// Drives bus reads, writes and device resets through several region settings.
// A behavioural copy of the command state machine and flash image predicts
// each result word; a monitor compares every strobed result against it.
// ============================================================================
`default_nettype none

module tb_cfi_flash_command_emulator_core;
    import cfe_pkg::*;

    localparam logic [1:0] CMD_UNUSED     = 2'd3;
    localparam longint     TIMEOUT_CYCLES = 6000000;
    localparam int         MAX_PRINTED    = 50;
    localparam int         IMG_AW         = $clog2(CFE_STORE_BYTES);

    typedef struct {
        logic [1:0]  command;
        logic [63:0] address;
        logic [3:0]  access_bytes;
        logic [63:0] write_data;
    } bus_access_t;

    typedef struct {
        logic [63:0] read_data;
        logic        range_error;
        logic        protocol_warning;
        int unsigned accept_cycle;
    } access_outcome_t;

    logic        clk              = 1'b0;
    logic        rst_n            = 1'b0;
    logic        start            = 1'b0;
    logic [1:0]  command          = '0;
    logic [63:0] address          = '0;
    logic [3:0]  access_bytes     = '0;
    logic [63:0] write_data       = '0;
    logic        cfg_valid        = 1'b0;
    logic [1:0]  cfg_index        = '0;
    logic [63:0] cfg_data         = '0;
    logic        busy;
    logic        done;
    logic [63:0] read_data;
    logic        range_error;
    logic        protocol_warning;
    logic        cfg_ready;

    cfi_flash_command_emulator_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .command          (command),
        .address          (address),
        .access_bytes     (access_bytes),
        .write_data       (write_data),
        .done             (done),
        .read_data        (read_data),
        .range_error      (range_error),
        .protocol_warning (protocol_warning),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #2 clk = ~clk;

    // flash image and command state as the block should hold them
    bit [7:0]     image_mem [CFE_STORE_BYTES];
    logic [31:0]  status_reg;
    read_mode_t   rmode;
    write_mode_t  wmode;
    logic [16:0]  words_left;
    logic [63:0]  cfg_base;
    logic [17:0]  cfg_bytes;

    bus_access_t     pending_accesses [$];
    access_outcome_t expected_outcomes [$];
    bus_access_t     held_access;

    int unsigned cycle_count     = 0;
    int unsigned items_accepted  = 0;
    int unsigned results_checked = 0;
    int unsigned mismatch_count  = 0;
    int unsigned region_settings = 0;
    int          burst_left      = 1;
    int          gap_left        = 0;

    logic [63:0] gen_base;
    int unsigned gen_span;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    function automatic void store_bytes(input longint unsigned off, input logic [63:0] data,
                                        input longint unsigned n);
        longint unsigned i;
        for (i = 0; i < n; i++)
            image_mem[IMG_AW'((off + i) % CFE_STORE_BYTES)] = data[8*i +: 8];
    endfunction

    function automatic logic apply_code(input logic [7:0] code);
        apply_code = 1'b0;
        case (code)
            CODE_READ_STATUS:    rmode = RM_STATUS;
            CODE_READ_ID:        rmode = RM_ID;
            CODE_CLEAR_STATUS:   status_reg = '0;
            CODE_BYTE_PROGRAM, CODE_BYTE_PROG_ALT:
            begin
                wmode = WM_BYTE;
                rmode = RM_STATUS;
            end
            CODE_BLOCK_ERASE:
            begin
                status_reg = READY_DUAL;
                wmode      = WM_ERASE;
                rmode      = RM_STATUS;
            end
            CODE_CONFIRM: ;
            CODE_BUFFER_PROGRAM:
            begin
                status_reg = READY_DUAL;
                wmode      = WM_LEN;
                rmode      = RM_STATUS;
            end
            CODE_READ_ARRAY, CODE_READ_ARRAY_ALT: rmode = RM_ARRAY;
            default:             apply_code = 1'b1;
        endcase
    endfunction

    function automatic access_outcome_t predict_access(input bus_access_t a);
        access_outcome_t r;
        longint unsigned span;
        longint unsigned off;
        longint unsigned n;
        longint unsigned len;
        longint unsigned i;
        logic [7:0]      code;
        r.read_data        = '0;
        r.range_error      = 1'b0;
        r.protocol_warning = 1'b0;
        r.accept_cycle     = 0;
        code = a.write_data[7:0];
        n    = 64'(a.access_bytes);
        if (a.command == CMD_RESET)
        begin
            status_reg = READY_DUAL;
            rmode      = RM_ARRAY;
            wmode      = WM_IDLE;
            words_left = '0;
            return r;
        end
        if (a.command == CMD_UNUSED)
            return r;
        span = (64'(cfg_bytes) < 64'(CFE_STORE_BYTES)) ? 64'(cfg_bytes)
                                                       : 64'(CFE_STORE_BYTES);
        if (n < 1 || n > 8 || a.address < cfg_base)
        begin
            r.range_error = 1'b1;
            return r;
        end
        off = a.address - cfg_base;
        if (off > span || span - off < n)
        begin
            r.range_error = 1'b1;
            return r;
        end
        if (a.command == CMD_READ)
        begin
            if (rmode == RM_ARRAY)
            begin
                for (i = 0; i < n; i++)
                    r.read_data[8*i +: 8] = image_mem[IMG_AW'((off + i) % CFE_STORE_BYTES)];
            end
            else if (rmode == RM_STATUS)
            begin
                r.read_data = {32'd0, status_reg};
                if (n < 8)
                    r.read_data &= (64'd1 << (8 * n)) - 64'd1;
            end
            return r;
        end
        case (wmode)
            WM_BYTE:
            begin
                store_bytes(off, a.write_data, n);
                status_reg = READY_DUAL;
                wmode      = WM_IDLE;
                rmode      = RM_STATUS;
            end
            WM_LEN:
            begin
                words_left = {1'b0, a.write_data[15:0]} + 17'd1;
                wmode      = WM_CONFIRM;
                rmode      = RM_STATUS;
            end
            WM_ERASE:
            begin
                if (code != CODE_CONFIRM)
                    r.protocol_warning = 1'b1;
                len = span - off;
                if (len > 64'(CFE_ERASE_BLOCK_BYTES))
                    len = 64'(CFE_ERASE_BLOCK_BYTES);
                for (i = 0; i < len; i++)
                    image_mem[IMG_AW'((off + i) % CFE_STORE_BYTES)] = 8'hFF;
                status_reg = READY_DUAL;
                wmode      = WM_IDLE;
                rmode      = RM_STATUS;
            end
            WM_CONFIRM:
            begin
                if (words_left == '0)
                begin
                    if (code != CODE_CONFIRM)
                    begin
                        r.protocol_warning = 1'b1;
                        void'(apply_code(code));
                    end
                    else
                    begin
                        wmode = WM_IDLE;
                        rmode = RM_STATUS;
                    end
                end
                else
                begin
                    if (n != 4)
                        r.protocol_warning = 1'b1;
                    store_bytes(off, a.write_data, n);
                    words_left = words_left - 17'd1;
                end
            end
            default: r.protocol_warning = apply_code(code);
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("mismatch at cycle %0d: %s, got %h, want %h (result %0d)",
                     cycle_count, what, got, want, results_checked);
    endtask

    // driver: hold a word until taken, idle in bursts
    always @(posedge clk)
    begin
        logic            launch;
        access_outcome_t outcome;
        launch = 1'b0;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                outcome              = predict_access(held_access);
                outcome.accept_cycle = cycle_count;
                expected_outcomes.push_back(outcome);
                items_accepted++;
            end
            if (!start || !busy)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_accesses.size() != 0)
                begin
                    held_access = pending_accesses.pop_front();
                    launch      = 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                        burst_left--;
                end
            end
            if (launch)
            begin
                command      <= held_access.command;
                address      <= held_access.address;
                access_bytes <= held_access.access_bytes;
                write_data   <= held_access.write_data;
                start        <= 1'b1;
            end
            else if (!start || !busy)
                start <= 1'b0;
        end
    end

    // monitor: results taken from a word accepted at an earlier edge only
    always @(posedge clk)
    begin
        access_outcome_t want;
        if (rst_n && done)
        begin
            if (expected_outcomes.size() == 0 ||
                expected_outcomes[0].accept_cycle >= cycle_count)
                report_mismatch("result with nothing expected", read_data, '0);
            else
            begin
                want = expected_outcomes.pop_front();
                if (read_data !== want.read_data)
                    report_mismatch("read_data", read_data, want.read_data);
                if (range_error !== want.range_error)
                    report_mismatch("range_error", {63'd0, range_error},
                                    {63'd0, want.range_error});
                if (protocol_warning !== want.protocol_warning)
                    report_mismatch("protocol_warning", {63'd0, protocol_warning},
                                    {63'd0, want.protocol_warning});
                results_checked++;
            end
        end
    end

    task automatic write_register(input logic [1:0] idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_REGION_BASE)
            cfg_base = value;
        else if (idx == REG_REGION_BYTES)
            cfg_bytes = value[17:0];
        @(posedge clk);
    endtask

    task automatic set_region(input logic [63:0] base, input int unsigned bytes);
        write_register(REG_REGION_BASE, base);
        write_register(REG_REGION_BYTES, {46'd0, bytes[17:0]});
        gen_base = base;
        gen_span = bytes;
        region_settings++;
        @(negedge clk);
    endtask

    task automatic drain_phase();
        do
            @(negedge clk);
        while (pending_accesses.size() != 0 || start || busy ||
               expected_outcomes.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    function automatic void queue_access(input logic [1:0] cmd, input logic [63:0] addr,
                                         input logic [3:0] n, input logic [63:0] data);
        bus_access_t a;
        a.command      = cmd;
        a.address      = addr;
        a.access_bytes = n;
        a.write_data   = data;
        pending_accesses.push_back(a);
    endfunction

    function automatic logic [63:0] code_word(input logic [7:0] code);
        code_word      = {$urandom, $urandom};
        code_word[7:0] = code;
    endfunction

    function automatic logic [63:0] rand_word();
        rand_word = {$urandom, $urandom};
    endfunction

    function automatic logic [3:0] rand_len();
        rand_len = 4'($urandom_range(1, 8));
    endfunction

    function automatic logic [63:0] addr_in(input int unsigned n);
        if (gen_span < n)
            addr_in = gen_base + $urandom_range(0, 3);
        else
            addr_in = gen_base + $urandom_range(0, gen_span - n);
    endfunction

    function automatic logic [63:0] erase_addr();
        if (gen_span > 4096)
            erase_addr = gen_base + gen_span - $urandom_range(1, 1024);
        else
            erase_addr = addr_in(1);
    endfunction

    function automatic logic [7:0] pick_code();
        logic [7:0] codes [10];
        codes = '{CODE_READ_ARRAY, CODE_READ_ARRAY_ALT, CODE_READ_STATUS, CODE_READ_ID,
                  CODE_CLEAR_STATUS, CODE_BYTE_PROGRAM, CODE_BYTE_PROG_ALT,
                  CODE_BLOCK_ERASE, CODE_BUFFER_PROGRAM, CODE_CONFIRM};
        if ($urandom_range(0, 4) == 0)
            pick_code = 8'($urandom_range(0, 255));
        else
            pick_code = codes[4'($urandom_range(0, 9))];
    endfunction

    function automatic void queue_array_read();
        logic [3:0] n;
        n = rand_len();
        queue_access(CMD_WRITE, addr_in(1), rand_len(), code_word(CODE_READ_ARRAY));
        queue_access(CMD_READ, addr_in(n), n, rand_word());
    endfunction

    function automatic void queue_random_runs(input int unsigned target);
        int unsigned before_size;
        int unsigned added;
        int unsigned kind;
        int unsigned words;
        int unsigned k;
        logic [3:0]  n;
        logic [63:0] data;
        logic [7:0]  codes_rd [4];
        codes_rd = '{CODE_READ_ARRAY, CODE_READ_ARRAY_ALT, CODE_READ_STATUS, CODE_READ_ID};
        added = 0;
        while (added < target)
        begin
            before_size = pending_accesses.size();
            kind = $urandom_range(0, 99);
            if (kind < 70 && $urandom_range(0, 3) == 0)
                queue_access(CMD_RESET, rand_word(), 4'($urandom_range(0, 15)), rand_word());
            if (kind < 15)
            begin
                queue_access(CMD_WRITE, addr_in(1), rand_len(),
                             code_word($urandom_range(0, 1) ? CODE_BYTE_PROGRAM
                                                            : CODE_BYTE_PROG_ALT));
                n = rand_len();
                queue_access(CMD_WRITE, addr_in(n), n, rand_word());
                n = rand_len();
                queue_access(CMD_READ, addr_in(n), n, rand_word());
                queue_array_read();
            end
            else if (kind < 35)
            begin
                queue_access(CMD_WRITE, addr_in(1), rand_len(), code_word(CODE_BUFFER_PROGRAM));
                words = $urandom_range(0, 5);
                data  = rand_word();
                data[15:0] = 16'(words);
                queue_access(CMD_WRITE, addr_in(2), 2, data);
                for (k = 0; k <= words; k++)
                begin
                    n = ($urandom_range(0, 9) == 0) ? rand_len() : 4'd4;
                    queue_access(CMD_WRITE, addr_in(n), n, rand_word());
                end
                queue_access(CMD_WRITE, addr_in(1), rand_len(),
                             code_word(($urandom_range(0, 6) == 0) ? pick_code() : CODE_CONFIRM));
                queue_array_read();
            end
            else if (kind < 45)
            begin
                queue_access(CMD_WRITE, addr_in(1), rand_len(), code_word(CODE_BLOCK_ERASE));
                queue_access(CMD_WRITE, erase_addr(), 1,
                             code_word(($urandom_range(0, 6) == 0) ? pick_code() : CODE_CONFIRM));
                n = rand_len();
                queue_access(CMD_READ, addr_in(n), n, rand_word());
                queue_array_read();
            end
            else if (kind < 60)
            begin
                queue_access(CMD_WRITE, addr_in(1), rand_len(),
                             code_word(codes_rd[2'($urandom_range(0, 3))]));
                words = $urandom_range(1, 3);
                for (k = 0; k < words; k++)
                begin
                    n = 4'($urandom_range(1, 8));
                    queue_access(CMD_READ, addr_in(n), n, rand_word());
                end
            end
            else if (kind < 70)
            begin
                queue_access(CMD_WRITE, addr_in(1), rand_len(), code_word(CODE_CLEAR_STATUS));
                queue_access(CMD_WRITE, addr_in(1), rand_len(), code_word(CODE_READ_STATUS));
                n = rand_len();
                queue_access(CMD_READ, addr_in(n), n, rand_word());
            end
            else if (kind < 80)
            begin
                n = rand_len();
                case ($urandom_range(0, 3))
                    0: data = gen_base - $urandom_range(1, 16);
                    1: data = gen_base + gen_span - n + $urandom_range(1, 8);
                    2:
                    begin
                        n    = 4'd0;
                        data = addr_in(1);
                    end
                    default:
                    begin
                        n    = 4'($urandom_range(9, 15));
                        data = addr_in(1);
                    end
                endcase
                queue_access($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, data, n,
                             code_word(pick_code()));
            end
            else if (kind < 90)
            begin
                n    = 4'($urandom_range(0, 15));
                data = ($urandom_range(0, 1) == 0) ? rand_word() : addr_in(n);
                queue_access(2'($urandom_range(0, 3)), data, n, code_word(pick_code()));
            end
            else if (kind < 95)
                queue_access(CMD_RESET, rand_word(), 4'($urandom_range(0, 15)), rand_word());
            else
                queue_access(CMD_WRITE, addr_in(1), rand_len(),
                             code_word($urandom_range(0, 1) ? CODE_CONFIRM
                                                            : 8'($urandom_range(0, 255))));
            added += pending_accesses.size() - before_size;
        end
    endfunction

    task automatic queue_directed();
        logic [63:0] b;
        logic [63:0] data;
        b = gen_base;
        queue_access(CMD_READ, b, 8, rand_word());
        queue_access(CMD_READ, b, 0, rand_word());
        queue_access(CMD_READ, b, 15, rand_word());
        queue_access(CMD_READ, b - 1, 1, rand_word());
        queue_access(CMD_READ, b + 249, 8, rand_word());
        queue_access(CMD_UNUSED, b, 4, rand_word());
        queue_access(CMD_WRITE, b, 1, code_word(CODE_READ_ID));
        queue_access(CMD_READ, b, 4, rand_word());
        queue_access(CMD_WRITE, b, 1, code_word(CODE_READ_STATUS));
        queue_access(CMD_READ, b + 8, 3, rand_word());
        queue_access(CMD_READ, b + 248, 8, rand_word());
        queue_access(CMD_WRITE, b, 1, code_word(CODE_CLEAR_STATUS));
        queue_access(CMD_READ, b, 4, rand_word());
        queue_access(CMD_WRITE, b, 1, code_word(CODE_BYTE_PROG_ALT));
        queue_access(CMD_WRITE, b, 8, 64'h0123_4567_89AB_CDEF);
        queue_access(CMD_READ, b, 2, rand_word());
        queue_access(CMD_WRITE, b, 1, code_word(CODE_BYTE_PROGRAM));
        queue_access(CMD_WRITE, b + 255, 1, 64'hFFFF_FFFF_FFFF_FF5A);
        queue_access(CMD_WRITE, b, 1, code_word(CODE_BUFFER_PROGRAM));
        data = rand_word();
        data[15:0] = 16'd1;
        queue_access(CMD_WRITE, b, 2, data);
        queue_access(CMD_WRITE, b + 32, 4, rand_word());
        queue_access(CMD_WRITE, b + 36, 2, rand_word());
        queue_access(CMD_WRITE, b, 1, code_word(CODE_READ_STATUS));
        queue_access(CMD_WRITE, b, 1, code_word(CODE_CONFIRM));
        queue_access(CMD_WRITE, b, 1, code_word(CODE_READ_ARRAY_ALT));
        queue_access(CMD_READ, b + 32, 8, rand_word());
        queue_access(CMD_WRITE, b, 1, code_word(CODE_BLOCK_ERASE));
        queue_access(CMD_WRITE, b + 200, 1, code_word(8'h33));
        queue_access(CMD_WRITE, b, 1, code_word(8'h00));
        queue_access(CMD_WRITE, b, 1, code_word(CODE_CONFIRM));
        queue_access(CMD_WRITE, b, 1, code_word(CODE_BUFFER_PROGRAM));
        queue_access(CMD_WRITE, b, 2, 64'h0000_0000_0000_FFFF);
        queue_access(CMD_RESET, b, 8, rand_word());
        queue_access(CMD_READ, b + 248, 8, rand_word());
    endtask

    task automatic queue_full_block();
        logic [63:0] b;
        b = gen_base;
        queue_access(CMD_WRITE, b, 1, code_word(CODE_BYTE_PROGRAM));
        queue_access(CMD_WRITE, b + 65532, 8, rand_word());
        queue_access(CMD_WRITE, b, 1, code_word(CODE_BYTE_PROGRAM));
        queue_access(CMD_WRITE, b + 131064, 8, rand_word());
        queue_access(CMD_WRITE, b, 1, code_word(CODE_BLOCK_ERASE));
        queue_access(CMD_WRITE, b, 1, code_word(CODE_CONFIRM));
        queue_access(CMD_WRITE, b, 1, code_word(CODE_READ_ARRAY));
        queue_access(CMD_READ, b + 65532, 8, rand_word());
        queue_access(CMD_WRITE, b, 1, code_word(CODE_BLOCK_ERASE));
        queue_access(CMD_WRITE, b + 100000, 1, code_word(CODE_CONFIRM));
        queue_access(CMD_WRITE, b, 1, code_word(CODE_READ_ARRAY));
        queue_access(CMD_READ, b + 131064, 8, rand_word());
        queue_access(CMD_READ, b + 131065, 8, rand_word());
    endtask

    function automatic void reset_image();
        int i;
        for (i = 0; i < CFE_STORE_BYTES; i++)
            image_mem[IMG_AW'(i)] = 8'hFF;
        status_reg = READY_DUAL;
        rmode      = RM_ARRAY;
        wmode      = WM_IDLE;
        words_left = '0;
        cfg_base   = '0;
        cfg_bytes  = '0;
    endfunction

    initial
    begin
        int p;
        reset_image();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_region(64'h0000_0000_0000_1000, 256);
        queue_directed();
        drain_phase();

        set_region(64'd0, 0);
        queue_random_runs(40);
        drain_phase();

        set_region(64'hFFFF_FFFF_FFFF_FF00, 256);
        queue_random_runs(150);
        drain_phase();

        set_region({1'b0, 31'($urandom), $urandom}, CFE_STORE_BYTES);
        queue_full_block();
        queue_random_runs(120);
        drain_phase();

        set_region(rand_word(), 1);
        queue_random_runs(30);
        drain_phase();

        for (p = 0; p < 6; p++)
        begin
            set_region({1'b0, 31'($urandom), $urandom}, $urandom_range(2, 2048));
            queue_random_runs(110);
            drain_phase();
        end

        repeat (20) @(posedge clk);
        if (expected_outcomes.size() != 0)
            report_mismatch("results never arrived", 64'(expected_outcomes.size()), '0);
        $display("covered %0d bus accesses over %0d region settings, %0d results checked",
                 items_accepted, region_settings, results_checked);
        $display("mismatches seen: %0d", mismatch_count);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * 4);
        $display("timeout after %0d cycles", cycle_count);
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
src/cfe_pkg.sv
src/cfe_store.sv
src/cfe_seq.sv
src/cfi_flash_command_emulator_core.sv
tb/tb_cfi_flash_command_emulator_core.sv
